// File: src/ssi_pkg.sv
`timescale 1ns / 1ps
package ssi_pkg;

	localparam int DEF_COUNT_BITS = 16;

	localparam int NUM_POINTS_W = 16;
	localparam int STEP_W = 32;
	localparam int SAMPLE_W = 32;
	localparam int RESULT_W = 64;
	localparam int S_ACC_W = 52;
	localparam int T_ACC_W = 36;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_NUM_POINTS = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_H = 1'b1;

	localparam logic [NUM_POINTS_W-1:0] NUM_POINTS_RST = 16'd3;
	localparam logic [STEP_W-1:0] STEP_H_RST = 32'd16777216;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	typedef enum logic [2:0] {
		WGT_0 = 3'd0,
		WGT_1 = 3'd1,
		WGT_2 = 3'd2,
		WGT_3 = 3'd3,
		WGT_4 = 3'd4
	} weight_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
		weight_t ws;
		weight_t wt;
		logic last;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

	typedef struct packed {
		logic signed [S_ACC_W-1:0] s_re;
		logic signed [S_ACC_W-1:0] s_im;
		logic signed [T_ACC_W-1:0] t_re;
		logic signed [T_ACC_W-1:0] t_im;
	} sums_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] re;
		logic signed [RESULT_W-1:0] im;
		logic sat;
	} result_t;

	localparam int RESULT_BITS = $bits(result_t);

endpackage

// File: src/simpson_stream_integrator.sv
`timescale 1ns / 1ps
// Streaming Simpson integrator for complex Q15.16 samples on a grid of step h (Q8.24).
// One sample is taken per clock cycle while full is low, with no gaps between runs. On
// the last sample of a run of num_points samples, one Q31.32 result (saturated, with a
// clip flag) goes to the output queue through the scaling pipeline: the weighted sums
// feed four multipliers by step_h and then a division by three that yields one quotient
// byte per stage. Up to eight results may be waiting or in flight; when that many are
// outstanding, the last sample of the next run waits in the input queue. Write num_points
// and step_h through the configuration port only while no run is open or wait for pending
// results as needed; num_points applies from the next sample, step_h to results in flight.
module simpson_stream_integrator #(
	parameter int COUNT_BITS = ssi_pkg::DEF_COUNT_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [ssi_pkg::SAMPLE_W-1:0] sample_re,
	input logic signed [ssi_pkg::SAMPLE_W-1:0] sample_im,
	output logic empty,
	input logic pop,
	output logic signed [ssi_pkg::RESULT_W-1:0] integral_re,
	output logic signed [ssi_pkg::RESULT_W-1:0] integral_im,
	output logic saturated,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ssi_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [ssi_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ssi_pkg::*;

	logic [NUM_POINTS_W-1:0] num_points_q;
	logic [STEP_W-1:0] step_h_q;
	logic in_xfer;
	logic out_xfer;
	item_t front_item;
	item_t mid_item;
	logic mid_empty;
	logic mid_pop;
	logic sums_valid;
	sums_t sums;
	logic res_valid;
	result_t res;
	result_t out_item;
	logic out_full;

	assign cfg_ready = 1'b1;
	assign in_xfer = push && !full;
	assign out_xfer = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q <= NUM_POINTS_RST;
			step_h_q <= STEP_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NUM_POINTS: num_points_q <= cfg_data[NUM_POINTS_W-1:0];
				REG_STEP_H: step_h_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	ssi_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.num_points(num_points_q),
		.accept(in_xfer),
		.sample_re(sample_re),
		.sample_im(sample_im),
		.item(front_item)
	);

	ssi_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(in_xfer),
		.wr_data(front_item),
		.rd_en(mid_pop),
		.rd_data(mid_item),
		.empty(mid_empty),
		.full(full)
	);

	ssi_accum u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.mid_empty(mid_empty),
		.item(mid_item),
		.mid_pop(mid_pop),
		.res_pop(out_xfer),
		.sums_valid(sums_valid),
		.sums(sums)
	);

	ssi_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.step_h(step_h_q),
		.sums_valid(sums_valid),
		.sums(sums),
		.res_valid(res_valid),
		.result(res)
	);

	ssi_fifo #(
		.WIDTH(RESULT_BITS),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(res_valid),
		.wr_data(res),
		.rd_en(out_xfer),
		.rd_data(out_item),
		.empty(empty),
		.full(out_full)
	);

	assign integral_re = out_item.re;
	assign integral_im = out_item.im;
	assign saturated = out_item.sat;

`ifndef SYNTHESIS
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_full)
		else $error("Result arrived while the output queue was full.");
`endif

endmodule

// File: src/ssi_fifo.sv
`timescale 1ns / 1ps
module ssi_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic empty,
	output logic full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == CW'(DEPTH));
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + CW'(1);
				2'b01: cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("Write to a full queue.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("Read from an empty queue.");
`endif

endmodule

// File: src/ssi_front.sv
`timescale 1ns / 1ps
module ssi_front #(
	parameter int COUNT_BITS = ssi_pkg::DEF_COUNT_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic [ssi_pkg::NUM_POINTS_W-1:0] num_points,
	input logic accept,
	input logic signed [ssi_pkg::SAMPLE_W-1:0] sample_re,
	input logic signed [ssi_pkg::SAMPLE_W-1:0] sample_im,
	output ssi_pkg::item_t item
);
	import ssi_pkg::*;

	localparam int NW = ((COUNT_BITS > NUM_POINTS_W) ? COUNT_BITS : NUM_POINTS_W) + 1;
	localparam logic [NW-1:0] N_MAX = NW'(1) << COUNT_BITS;

	logic [COUNT_BITS-1:0] index_q;
	logic [NW-1:0] n_pts;
	logic [NW-1:0] n_last;
	logic [NW-1:0] m_pts;
	logic [NW-1:0] tail_start;
	logic [NW-1:0] idx;
	logic [NW-1:0] pos;
	logic [NW-1:0] k;
	logic odd;

	always_comb begin
		n_pts = NW'(num_points);
		if (n_pts > N_MAX) begin
			n_pts = N_MAX;
		end
		if (n_pts < NW'(3)) begin
			n_pts = NW'(3);
		end
		n_last = n_pts - NW'(1);
		odd = n_pts[0];
		m_pts = odd ? n_pts : n_pts - NW'(3);
		tail_start = n_pts - NW'(4);
		idx = NW'(index_q);
		pos = (idx > n_last) ? n_last : idx;
		k = pos - tail_start;

		item.re = sample_re;
		item.im = sample_im;
		item.last = (pos == n_last);

		if (m_pts < NW'(3) || pos >= m_pts) begin
			item.ws = WGT_0;
		end else if (pos == '0 || pos == m_pts - NW'(1)) begin
			item.ws = WGT_1;
		end else if (pos[0]) begin
			item.ws = WGT_4;
		end else begin
			item.ws = WGT_2;
		end

		if (odd || pos < tail_start) begin
			item.wt = WGT_0;
		end else if (k == NW'(0) || k == NW'(3)) begin
			item.wt = WGT_1;
		end else begin
			item.wt = WGT_3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
		end else if (accept) begin
			index_q <= item.last ? '0 : index_q + COUNT_BITS'(1);
		end
	end

endmodule

// File: src/ssi_accum.sv
`timescale 1ns / 1ps
module ssi_accum (
	input logic clk,
	input logic arst_n,
	input logic mid_empty,
	input ssi_pkg::item_t item,
	output logic mid_pop,
	input logic res_pop,
	output logic sums_valid,
	output ssi_pkg::sums_t sums
);
	import ssi_pkg::*;

	localparam int CW = $clog2(OUT_DEPTH + 1);

	// Results that have left this stage and have not yet been transferred out.
	logic [CW-1:0] credit_q;
	logic take;
	logic issue;
	logic signed [S_ACC_W-1:0] s_re_q;
	logic signed [S_ACC_W-1:0] s_im_q;
	logic signed [T_ACC_W-1:0] t_re_q;
	logic signed [T_ACC_W-1:0] t_im_q;
	logic signed [S_ACC_W-1:0] s_re_nx;
	logic signed [S_ACC_W-1:0] s_im_nx;
	logic signed [T_ACC_W-1:0] t_re_nx;
	logic signed [T_ACC_W-1:0] t_im_nx;
	logic sums_valid_s1;
	sums_t sums_s1;

	function automatic logic signed [S_ACC_W-1:0] weigh_s(input weight_t w,
			input logic signed [SAMPLE_W-1:0] x);
		logic signed [S_ACC_W-1:0] xe;
		logic signed [S_ACC_W-1:0] r;
		xe = {{(S_ACC_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
		case (w)
			WGT_1: r = xe;
			WGT_2: r = xe <<< 1;
			WGT_4: r = xe <<< 2;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [T_ACC_W-1:0] weigh_t(input weight_t w,
			input logic signed [SAMPLE_W-1:0] x);
		logic signed [T_ACC_W-1:0] xe;
		logic signed [T_ACC_W-1:0] r;
		xe = {{(T_ACC_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
		case (w)
			WGT_1: r = xe;
			WGT_3: r = (xe <<< 1) + xe;
			default: r = '0;
		endcase
		return r;
	endfunction

	assign take = !mid_empty && (!item.last || (credit_q < CW'(OUT_DEPTH)));
	assign issue = take && item.last;
	assign mid_pop = take;
	assign sums_valid = sums_valid_s1;
	assign sums = sums_s1;

	assign s_re_nx = s_re_q + weigh_s(item.ws, item.re);
	assign s_im_nx = s_im_q + weigh_s(item.ws, item.im);
	assign t_re_nx = t_re_q + weigh_t(item.wt, item.re);
	assign t_im_nx = t_im_q + weigh_t(item.wt, item.im);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_re_q <= '0;
			s_im_q <= '0;
			t_re_q <= '0;
			t_im_q <= '0;
			credit_q <= '0;
			sums_valid_s1 <= 1'b0;
		end else begin
			sums_valid_s1 <= issue;
			if (take) begin
				if (item.last) begin
					s_re_q <= '0;
					s_im_q <= '0;
					t_re_q <= '0;
					t_im_q <= '0;
				end else begin
					s_re_q <= s_re_nx;
					s_im_q <= s_im_nx;
					t_re_q <= t_re_nx;
					t_im_q <= t_im_nx;
				end
			end
			case ({issue, res_pop})
				2'b10: credit_q <= credit_q + CW'(1);
				2'b01: credit_q <= credit_q - CW'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sums_s1.s_re <= s_re_nx;
			sums_s1.s_im <= s_im_nx;
			sums_s1.t_re <= t_re_nx;
			sums_s1.t_im <= t_im_nx;
		end
	end

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CW'(OUT_DEPTH))
		else $error("More results in flight than the output queue holds.");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> (s_re_q == '0 && s_im_q == '0 && t_re_q == '0 && t_im_q == '0))
		else $error("Accumulators not cleared after the last sample of a run.");
`endif

endmodule

// File: src/ssi_scale.sv
`timescale 1ns / 1ps
module ssi_scale (
	input logic clk,
	input logic arst_n,
	input logic [ssi_pkg::STEP_W-1:0] step_h,
	input logic sums_valid,
	input ssi_pkg::sums_t sums,
	output logic res_valid,
	output ssi_pkg::result_t result
);
	import ssi_pkg::*;

	localparam int PW = 56;
	localparam int LOW_W = 32;
	localparam int PLO_W = LOW_W + STEP_W;
	localparam int PHI_W = PW - LOW_W + STEP_W;
	localparam int PRODW = PW + STEP_W;
	localparam int SHIFT = 11;
	localparam int XW = PRODW - SHIFT;
	localparam int DW = 72;
	localparam int KEEP_W = 65;
	localparam int DIV_STEPS = DW / 8;
	localparam int LAT = 5 + DIV_STEPS;
	localparam logic [PRODW-1:0] RND_BIAS = PRODW'(3072);
	localparam logic [XW-1:0] SAT_POS = XW'(3) << (RESULT_W - 1);
	localparam logic [XW-1:0] SAT_NEG = SAT_POS + XW'(3);
	localparam logic [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W - 1){1'b1}}};
	localparam logic [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W - 1){1'b0}}};

	logic v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [PW-1:0] p_re_s2, p_im_s2;
	logic neg_re_s3, neg_im_s3, neg_re_s4, neg_im_s4;
	logic neg_re_s5, neg_im_s5, neg_re_s6, neg_im_s6;
	logic [PW-1:0] mag_re_s3, mag_im_s3;
	logic [PLO_W-1:0] plo_re_s4, plo_im_s4;
	logic [PHI_W-1:0] phi_re_s4, phi_im_s4;
	logic [PRODW-1:0] sum_re, sum_im;
	logic [XW-1:0] x_re_s5, x_im_s5;
	logic sat_re_s6, sat_im_s6;
	logic [DW-1:0] dvd_re_s6, dvd_im_s6;

	// Stages s7 to s15: one quotient byte of the division by three per stage.
	logic dv_v_s [DIV_STEPS];
	logic dv_neg_re_s [DIV_STEPS];
	logic dv_neg_im_s [DIV_STEPS];
	logic dv_sat_re_s [DIV_STEPS];
	logic dv_sat_im_s [DIV_STEPS];
	logic [DW-1:0] dv_x_re_s [DIV_STEPS];
	logic [DW-1:0] dv_x_im_s [DIV_STEPS];
	logic [DW-1:0] dv_q_re_s [DIV_STEPS];
	logic [DW-1:0] dv_q_im_s [DIV_STEPS];
	logic [1:0] dv_r_re_s [DIV_STEPS];
	logic [1:0] dv_r_im_s [DIV_STEPS];

	function automatic logic signed [PW-1:0] weigh(input logic signed [S_ACC_W-1:0] s,
			input logic signed [T_ACC_W-1:0] t);
		logic signed [PW-1:0] se;
		logic signed [PW-1:0] te;
		se = {{(PW - S_ACC_W){s[S_ACC_W-1]}}, s};
		te = {{(PW - T_ACC_W){t[T_ACC_W-1]}}, t};
		return (se <<< 3) + (te <<< 3) + te;
	endfunction

	function automatic logic [9:0] div3_byte(input logic [1:0] r_in, input logic [7:0] d);
		logic [2:0] t;
		logic [1:0] r;
		logic [7:0] q;
		r = r_in;
		q = '0;
		for (int b = 7; b >= 0; b--) begin
			t = {r, d[b]};
			if (t >= 3'd3) begin
				q[b] = 1'b1;
				r = 2'(t - 3'd3);
			end else begin
				r = t[1:0];
			end
		end
		return {r, q};
	endfunction

	function automatic logic [RESULT_W-1:0] finish(input logic neg, input logic sat,
			input logic [DW-1:0] q);
		logic [RESULT_W-1:0] r;
		if (sat) begin
			r = neg ? RES_MIN : RES_MAX;
		end else begin
			r = neg ? RESULT_W'(0) - q[RESULT_W-1:0] : q[RESULT_W-1:0];
		end
		return r;
	endfunction

	assign sum_re = {{(PRODW - PLO_W){1'b0}}, plo_re_s4} + {phi_re_s4, {LOW_W{1'b0}}}
		+ RND_BIAS;
	assign sum_im = {{(PRODW - PLO_W){1'b0}}, plo_im_s4} + {phi_im_s4, {LOW_W{1'b0}}}
		+ RND_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s2 <= sums_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		p_re_s2 <= weigh(sums.s_re, sums.t_re);
		p_im_s2 <= weigh(sums.s_im, sums.t_im);

		neg_re_s3 <= p_re_s2[PW-1];
		neg_im_s3 <= p_im_s2[PW-1];
		mag_re_s3 <= p_re_s2[PW-1] ? PW'(0) - p_re_s2 : p_re_s2;
		mag_im_s3 <= p_im_s2[PW-1] ? PW'(0) - p_im_s2 : p_im_s2;

		neg_re_s4 <= neg_re_s3;
		neg_im_s4 <= neg_im_s3;
		plo_re_s4 <= mag_re_s3[LOW_W-1:0] * step_h;
		plo_im_s4 <= mag_im_s3[LOW_W-1:0] * step_h;
		phi_re_s4 <= mag_re_s3[PW-1:LOW_W] * step_h;
		phi_im_s4 <= mag_im_s3[PW-1:LOW_W] * step_h;

		neg_re_s5 <= neg_re_s4;
		neg_im_s5 <= neg_im_s4;
		x_re_s5 <= sum_re[PRODW-1:SHIFT];
		x_im_s5 <= sum_im[PRODW-1:SHIFT];

		neg_re_s6 <= neg_re_s5;
		neg_im_s6 <= neg_im_s5;
		sat_re_s6 <= (x_re_s5 >= (neg_re_s5 ? SAT_NEG : SAT_POS));
		sat_im_s6 <= (x_im_s5 >= (neg_im_s5 ? SAT_NEG : SAT_POS));
		dvd_re_s6 <= {{(DW - KEEP_W){1'b0}}, x_re_s5[KEEP_W-1:0]};
		dvd_im_s6 <= {{(DW - KEEP_W){1'b0}}, x_im_s5[KEEP_W-1:0]};
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic v_in;
		logic neg_re_in, neg_im_in, sat_re_in, sat_im_in;
		logic [DW-1:0] x_re_in, x_im_in, q_re_in, q_im_in;
		logic [1:0] r_re_in, r_im_in;
		logic [9:0] st_re, st_im;

		if (j == 0) begin : g_first
			assign v_in = v_s6;
			assign neg_re_in = neg_re_s6;
			assign neg_im_in = neg_im_s6;
			assign sat_re_in = sat_re_s6;
			assign sat_im_in = sat_im_s6;
			assign x_re_in = dvd_re_s6;
			assign x_im_in = dvd_im_s6;
			assign q_re_in = '0;
			assign q_im_in = '0;
			assign r_re_in = '0;
			assign r_im_in = '0;
		end else begin : g_next
			assign v_in = dv_v_s[j-1];
			assign neg_re_in = dv_neg_re_s[j-1];
			assign neg_im_in = dv_neg_im_s[j-1];
			assign sat_re_in = dv_sat_re_s[j-1];
			assign sat_im_in = dv_sat_im_s[j-1];
			assign x_re_in = dv_x_re_s[j-1];
			assign x_im_in = dv_x_im_s[j-1];
			assign q_re_in = dv_q_re_s[j-1];
			assign q_im_in = dv_q_im_s[j-1];
			assign r_re_in = dv_r_re_s[j-1];
			assign r_im_in = dv_r_im_s[j-1];
		end

		assign st_re = div3_byte(r_re_in, x_re_in[DW-1 -: 8]);
		assign st_im = div3_byte(r_im_in, x_im_in[DW-1 -: 8]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else begin
				dv_v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			dv_neg_re_s[j] <= neg_re_in;
			dv_neg_im_s[j] <= neg_im_in;
			dv_sat_re_s[j] <= sat_re_in;
			dv_sat_im_s[j] <= sat_im_in;
			dv_x_re_s[j] <= x_re_in << 8;
			dv_x_im_s[j] <= x_im_in << 8;
			dv_q_re_s[j] <= {q_re_in[DW-9:0], st_re[7:0]};
			dv_q_im_s[j] <= {q_im_in[DW-9:0], st_im[7:0]};
			dv_r_re_s[j] <= st_re[9:8];
			dv_r_im_s[j] <= st_im[9:8];
		end
	end

	always_comb begin
		res_valid = dv_v_s[DIV_STEPS-1];
		result.re = finish(dv_neg_re_s[DIV_STEPS-1], dv_sat_re_s[DIV_STEPS-1],
			dv_q_re_s[DIV_STEPS-1]);
		result.im = finish(dv_neg_im_s[DIV_STEPS-1], dv_sat_im_s[DIV_STEPS-1],
			dv_q_im_s[DIV_STEPS-1]);
		result.sat = dv_sat_re_s[DIV_STEPS-1] || dv_sat_im_s[DIV_STEPS-1];
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sums_valid |-> ##LAT res_valid)
		else $error("Scaled result did not appear after the pipeline latency.");
`endif

endmodule
